>>> rtl/core/lrd_pkg.sv
// lrd_pkg: shared types and constants of the led row driver command slave
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lrd_pkg;

   // display geometry
   localparam int LINES       = 8;
   localparam int LINE_IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CNT_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int WIDTH_W     = 4;
   localparam int RSP_DATA_W  = 24;

   // protocol codes and reset values
   localparam logic [BYTE_W-1:0]  ADDR_CHANGE_CODE = 8'hFE;
   localparam logic [BYTE_W-1:0]  ADDR_RESET       = 8'h10;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET      = 4'd8;
   localparam logic [CNT_W-1:0]   LINES_RESET      = 4'd8;
   localparam logic [BYTE_W-1:0]  SELECT_ALL_OFF   = 8'hFF;

   // request kinds carried on req_tuser
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_REFRESH = 1'b1;

   // command byte parser
   typedef enum logic [1:0] {
      PROTO_IDLE,
      PROTO_HEADER,
      PROTO_PAYLOAD,
      PROTO_NEWADDR
   } proto_state_type;

   // refresh sequencer
   typedef enum logic {
      SEQ_IDLE,
      SEQ_SCAN
   } seq_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_addr;
      logic take_header;
      logic take_payload;
      logic start_scan;
      logic emit_line;
   } lrd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_change_code;
      logic addr_match;
      logic no_lines;
      logic last_line;
      logic out_free;
   } lrd_sts_type;

endpackage

>>> rtl/core/lrd_ctrl.sv
// lrd_ctrl: command byte parser and refresh sequencer state machines
// depends on lrd_pkg
`timescale 1ns / 1ps

module lrd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  lrd_pkg::lrd_sts_type sts,
   output lrd_pkg::lrd_cmd_type cmd
);
   import lrd_pkg::*;

   proto_state_type proto_ff, proto_in;
   seq_state_type   seq_ff, seq_in;
   logic            accept;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff <= PROTO_IDLE;
         seq_ff   <= SEQ_IDLE;
      end else begin
         proto_ff <= proto_in;
         seq_ff   <= seq_in;
      end
   end

   // next state and commands
   always_comb begin
      proto_in   = proto_ff;
      seq_in     = seq_ff;
      cmd        = '0;
      req_tready = (seq_ff == SEQ_IDLE);
      accept     = req_tvalid && req_tready;

      // command byte transaction
      if (accept && (req_tuser == OP_COMMAND)) begin
         case (proto_ff)
            PROTO_IDLE: begin
               if (sts.is_change_code) begin
                  proto_in = PROTO_NEWADDR;
               end else if (sts.addr_match) begin
                  proto_in = PROTO_HEADER;
               end
            end
            PROTO_NEWADDR: begin
               cmd.take_addr = 1'b1;
               proto_in      = PROTO_IDLE;
            end
            PROTO_HEADER: begin
               cmd.take_header = 1'b1;
               proto_in        = PROTO_PAYLOAD;
            end
            PROTO_PAYLOAD: begin
               cmd.take_payload = 1'b1;
               proto_in         = PROTO_IDLE;
            end
            default: begin
               proto_in = PROTO_IDLE;
            end
         endcase
      end

      // refresh sequencing
      case (seq_ff)
         SEQ_IDLE: begin
            if (accept && (req_tuser == OP_REFRESH) && !sts.no_lines) begin
               cmd.start_scan = 1'b1;
               seq_in         = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            if (sts.out_free) begin
               cmd.emit_line = 1'b1;
               if (sts.last_line) begin
                  seq_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/lrd_datapath.sv
// lrd_datapath: address, header and line store registers, scan counter, output register
// depends on lrd_pkg; driven by lrd_ctrl commands
`timescale 1ns / 1ps

module lrd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lrd_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrd_pkg::CNT_W-1:0]         csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lrd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  lrd_pkg::lrd_cmd_type              cmd,
   output lrd_pkg::lrd_sts_type              sts
);
   import lrd_pkg::*;

   logic [CNT_W-1:0]      lines_ff;
   logic [BYTE_W-1:0]     addr_ff;
   logic [WIDTH_W-1:0]    pend_width_ff;
   logic [CNT_W-1:0]      pend_line_ff;
   logic [WIDTH_W-1:0]    shared_width_ff;
   logic [BYTE_W-1:0]     store_ff [LINES];
   logic [LINE_IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      lines_clamped;
   logic [BYTE_W-1:0]     select_in;
   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     rsp_select_ff;
   logic [BYTE_W-1:0]     rsp_bits_ff;
   logic [WIDTH_W-1:0]    rsp_count_ff;
   logic                  rsp_last_ff;

   assign csr_ready = 1'b1;

   // clamp the scan length to the physical line count
   assign lines_clamped = (lines_ff > CNT_W'(LINES)) ? CNT_W'(LINES) : lines_ff;

   // status toward the controller
   assign sts.is_change_code = (req_tdata == ADDR_CHANGE_CODE);
   assign sts.addr_match     = (req_tdata == addr_ff);
   assign sts.no_lines       = (lines_clamped == '0);
   assign sts.last_line      = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign sts.out_free       = !rsp_valid_ff || rsp_tready;

   // line register
   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= LINES_RESET;
      end else if (csr_valid && csr_ready) begin
         lines_ff <= csr_data;
      end
   end

   // protocol registers and line store
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff         <= ADDR_RESET;
         pend_width_ff   <= '0;
         pend_line_ff    <= '0;
         shared_width_ff <= WIDTH_RESET;
         for (int i = 0; i < LINES; i++) begin
            store_ff[i] <= BYTE_W'(1 << (i % BYTE_W));
         end
      end else begin
         if (cmd.take_addr) begin
            addr_ff <= req_tdata;
         end
         if (cmd.take_header) begin
            pend_width_ff <= req_tdata[WIDTH_W-1:0];
            pend_line_ff  <= req_tdata[BYTE_W-1:WIDTH_W];
         end
         if (cmd.take_payload) begin
            shared_width_ff <= pend_width_ff;
            // out-of-range line index writes nothing
            if (pend_line_ff < CNT_W'(LINES)) begin
               store_ff[pend_line_ff[LINE_IDX_W-1:0]] <= req_tdata;
            end
         end
      end
   end

   // scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.start_scan) begin
         idx_ff   <= '0;
         count_ff <= lines_clamped;
      end else if (cmd.emit_line) begin
         idx_ff <= idx_ff + LINE_IDX_W'(1);
      end
   end

   // active-low one-hot select of the current line
   assign select_in = SELECT_ALL_OFF & ~(BYTE_W'(1) << idx_ff);

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_line) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.emit_line) begin
         rsp_select_ff <= select_in;
         rsp_bits_ff   <= store_ff[idx_ff];
         rsp_count_ff  <= shared_width_ff;
         rsp_last_ff   <= sts.last_line;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2*BYTE_W - WIDTH_W)'(0),
                        rsp_count_ff, rsp_bits_ff, rsp_select_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/core/led_row_driver_command_slave.sv
// led_row_driver_command_slave: top level, joins controller and datapath
// depends on lrd_pkg, lrd_ctrl, lrd_datapath
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata = data_byte, tuser = operation
//   rsp      out        rsp_tvalid/rsp_tready  tdata = select/bits/count, tlast = last line
//   csr      in         csr_valid/csr_ready    csr_data = lines_in_use
//
// a refresh scans n lines, one line a cycle while the output register is empty or rsp_tready is high,
// from the scan counter into the single output register.
// a refresh with zero lines gives no transaction.
// rsp_tready low while a line is held stalls the scan; req_tready is low while a scan is in progress.
// synchronous active-high reset restores address 0x10, width 8 and the store pattern.
`timescale 1ns / 1ps

module led_row_driver_command_slave (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lrd_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] data_byte
   input  logic                             req_tuser,   // [0] operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lrd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [7:0] row_select, [15:8] row_bits,
                                                         // [19:16] bit_count, [23:20] zero
   output logic                             rsp_tlast,   // last_line
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lrd_pkg::CNT_W-1:0]        csr_data
);
   import lrd_pkg::*;

   lrd_cmd_type cmd;
   lrd_sts_type sts;

   // control
   lrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   lrd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

>>> rtl/core/lrd_checker.sv
// lrd_checker: port-level assertions for led_row_driver_command_slave
// depends on lrd_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module lrd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lrd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import lrd_pkg::*;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // exactly one select line is active low
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tdata[BYTE_W-1:0]) == (BYTE_W - 1))
      else $error("row select is not one-hot active low");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:2*BYTE_W+WIDTH_W] == '0)
      else $error("rsp pad bits set");

   // no new request while a refresh still has lines to give
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during a refresh scan");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind led_row_driver_command_slave lrd_checker u_lrd_checker (.*);
